/* hw/rtl/ilte_pkg.sv */
// Shared types, codes and defaults for the indexed list table engine.
package ilte_pkg;

  localparam int DEPTH_DEF = 16;

  typedef enum logic [3:0] {
    OP_PUSH   = 4'd0,
    OP_POP    = 4'd1,
    OP_INSERT = 4'd2,
    OP_REMOVE = 4'd3,
    OP_READ   = 4'd4,
    OP_WRITE  = 4'd5,
    OP_FRONT  = 4'd6,
    OP_BACK   = 4'd7,
    OP_FIND   = 4'd8,
    OP_SWAP   = 4'd9,
    OP_SORT   = 4'd10,
    OP_CLEAR  = 4'd11
  } req_code_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [7:0]         position;
    logic [7:0]         other_position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         match_index;
    status_t            status;
    logic [4:0]         entry_count;
  } rsp_t;

  // Sequencer handshake toward the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } ctl_t;

  // Outcome of the shared compare unit.
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

/* hw/rtl/ilte_alu.sv */
// Shared signed compare unit used by find and sort.
module ilte_alu import ilte_pkg::*; (
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output cmp_t               res
);

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
  end

endmodule

/* hw/rtl/ilte_seq.sv */
// Request sequencer with the entry store and the entry count.
module ilte_seq import ilte_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  req_t req,
  input  logic out_free,
  output ctl_t ctl,
  output rsp_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_DEC      = 17'h00002,
    S_RDW      = 17'h00004,
    S_INS_RD   = 17'h00008,
    S_INS_WR   = 17'h00010,
    S_REM_RD   = 17'h00020,
    S_REM_WR   = 17'h00040,
    S_FIND_RD  = 17'h00080,
    S_FIND_CMP = 17'h00100,
    S_SWP_A    = 17'h00200,
    S_SWP_B    = 17'h00400,
    S_SWP_C    = 17'h00800,
    S_SRT_RD0  = 17'h01000,
    S_SRT_LD   = 17'h02000,
    S_SRT_RD   = 17'h04000,
    S_SRT_CMP  = 17'h08000,
    S_DONE     = 17'h10000
  } state_t;

  state_t             state, state_next;
  logic [3:0]         op, op_next;
  logic [PW-1:0]      pos, pos_next;
  logic [PW-1:0]      pos2, pos2_next;
  logic signed [31:0] val, val_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      lim, lim_next;
  logic signed [31:0] carry, carry_next;
  logic signed [31:0] rd, rd_next;
  logic [7:0]         match, match_next;
  status_t            stat, stat_next;

  logic [31:0]        mem [DEPTH];
  logic signed [31:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata;

  logic [PW-1:0]      cnt_p, idx_p;
  logic [CW-1:0]      cnt_m1, idx_m1, idx_p1;
  logic               pos_ok, pos2_ok;
  logic signed [31:0] alu_b;
  cmp_t               cmp;

  ilte_alu u_alu (
    .a   (rdata),
    .b   (alu_b),
    .res (cmp)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    cnt_p   = PW'(count);
    idx_p   = PW'(idx);
    cnt_m1  = count - ONE;
    idx_m1  = idx - ONE;
    idx_p1  = idx + ONE;
    pos_ok  = (pos < cnt_p);
    pos2_ok = (pos2 < cnt_p);
    alu_b   = (state == S_FIND_CMP) ? val : carry;
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    pos_next   = pos;
    pos2_next  = pos2;
    val_next   = val;
    count_next = count;
    idx_next   = idx;
    lim_next   = lim;
    carry_next = carry;
    rd_next    = rd;
    match_next = match;
    stat_next  = stat;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;

    case (state)
      S_IDLE: begin
        if (take) begin
          op_next    = req.req_type;
          pos_next   = PW'(req.position);
          pos2_next  = PW'(req.other_position);
          val_next   = req.item_value;
          state_next = S_DEC;
        end
      end

      S_DEC: begin
        rd_next    = '0;
        match_next = '0;
        stat_next  = ST_OK;
        state_next = S_DONE;
        case (op)
          OP_PUSH: begin
            if (count == CNT_MAX) begin
              stat_next = ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = count[AW-1:0];
              wdata      = val;
              count_next = count + ONE;
            end
          end
          OP_POP: begin
            if (count == '0) begin
              stat_next = ST_EMPTY;
            end else begin
              raddr      = cnt_m1[AW-1:0];
              count_next = cnt_m1;
              state_next = S_RDW;
            end
          end
          OP_INSERT: begin
            if (pos > cnt_p) begin
              stat_next = ST_RANGE;
            end else if (count == CNT_MAX) begin
              stat_next = ST_FULL;
            end else begin
              idx_next   = count;
              state_next = S_INS_RD;
            end
          end
          OP_REMOVE: begin
            if (!pos_ok) begin
              stat_next = ST_RANGE;
            end else begin
              idx_next   = pos[CW-1:0];
              state_next = S_REM_RD;
            end
          end
          OP_READ: begin
            if (!pos_ok) begin
              stat_next = ST_RANGE;
            end else begin
              raddr      = pos[AW-1:0];
              state_next = S_RDW;
            end
          end
          OP_WRITE: begin
            if (!pos_ok) begin
              stat_next = ST_RANGE;
            end else begin
              we    = 1'b1;
              waddr = pos[AW-1:0];
              wdata = val;
            end
          end
          OP_FRONT: begin
            if (count == '0) begin
              stat_next = ST_EMPTY;
            end else begin
              raddr      = '0;
              state_next = S_RDW;
            end
          end
          OP_BACK: begin
            if (count == '0) begin
              stat_next = ST_EMPTY;
            end else begin
              raddr      = cnt_m1[AW-1:0];
              state_next = S_RDW;
            end
          end
          OP_FIND: begin
            idx_next   = '0;
            state_next = S_FIND_RD;
          end
          OP_SWAP: begin
            if (!pos_ok || !pos2_ok) begin
              stat_next = ST_RANGE;
            end else begin
              raddr      = pos[AW-1:0];
              state_next = S_SWP_A;
            end
          end
          OP_SORT: begin
            if (count > ONE) begin
              lim_next   = count;
              state_next = S_SRT_RD0;
            end
          end
          OP_CLEAR: begin
            count_next = '0;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_RDW: begin
        rd_next    = rdata;
        state_next = S_DONE;
      end

      // Open the gap from the top down: move entry idx-1 to idx.
      S_INS_RD: begin
        if (idx_p == pos) begin
          we         = 1'b1;
          waddr      = idx[AW-1:0];
          wdata      = val;
          count_next = count + ONE;
          state_next = S_DONE;
        end else begin
          raddr      = idx_m1[AW-1:0];
          state_next = S_INS_WR;
        end
      end

      S_INS_WR: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        wdata      = rdata;
        idx_next   = idx_m1;
        state_next = S_INS_RD;
      end

      // Close the gap from the bottom up: move entry idx+1 to idx.
      S_REM_RD: begin
        if (idx_p1 >= count) begin
          count_next = cnt_m1;
          state_next = S_DONE;
        end else begin
          raddr      = idx_p1[AW-1:0];
          state_next = S_REM_WR;
        end
      end

      S_REM_WR: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        wdata      = rdata;
        idx_next   = idx_p1;
        state_next = S_REM_RD;
      end

      S_FIND_RD: begin
        if (idx >= count) begin
          stat_next  = ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          raddr      = idx[AW-1:0];
          state_next = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (cmp.eq) begin
          match_next = idx_p[7:0];
          state_next = S_DONE;
        end else begin
          idx_next   = idx_p1;
          state_next = S_FIND_RD;
        end
      end

      S_SWP_A: begin
        carry_next = rdata;
        raddr      = pos2[AW-1:0];
        state_next = S_SWP_B;
      end

      S_SWP_B: begin
        we         = 1'b1;
        waddr      = pos[AW-1:0];
        wdata      = rdata;
        state_next = S_SWP_C;
      end

      S_SWP_C: begin
        we         = 1'b1;
        waddr      = pos2[AW-1:0];
        wdata      = carry;
        state_next = S_DONE;
      end

      // One bubble pass: carry the largest entry seen toward slot lim-1.
      S_SRT_RD0: begin
        raddr      = '0;
        state_next = S_SRT_LD;
      end

      S_SRT_LD: begin
        carry_next = rdata;
        idx_next   = ONE;
        state_next = S_SRT_RD;
      end

      S_SRT_RD: begin
        if (idx >= lim) begin
          we    = 1'b1;
          waddr = idx_m1[AW-1:0];
          wdata = carry;
          if (lim == TWO) begin
            state_next = S_DONE;
          end else begin
            lim_next   = lim - ONE;
            state_next = S_SRT_RD0;
          end
        end else begin
          raddr      = idx[AW-1:0];
          state_next = S_SRT_CMP;
        end
      end

      S_SRT_CMP: begin
        we    = 1'b1;
        waddr = idx_m1[AW-1:0];
        if (cmp.lt) begin
          wdata = rdata;
        end else begin
          wdata      = carry;
          carry_next = rdata;
        end
        idx_next   = idx_p1;
        state_next = S_SRT_RD;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    pos   <= pos_next;
    pos2  <= pos2_next;
    val   <= val_next;
    idx   <= idx_next;
    lim   <= lim_next;
    carry <= carry_next;
    rd    <= rd_next;
    match <= match_next;
    stat  <= stat_next;
  end

  always_comb begin
    ctl.idle           = (state == S_IDLE);
    ctl.done           = (state == S_DONE) && out_free;
    result.read_value  = rd;
    result.match_index = match;
    result.status      = stat;
    result.entry_count = cnt_p[4:0];
  end

endmodule

/* hw/rtl/indexed_list_table_engine.sv */
// Top level of the indexed list table engine: request intake and result register.
//
// Requests arrive on req/req_valid; the engine raises req_stall while it works
// on one request and drops it again once that request's result has been
// handed to the result register. Results leave on rsp/rsp_valid and transfer
// at each edge where rsp_valid is high and rsp_stall is low. Every request
// produces exactly one result transfer.
//
// The entry store takes one read and one write per cycle and returns its read data
// registered; one signed compare unit is shared by find and sort. Insert and remove
// shift entries one at a time, find scans up from index zero, and sort runs bubble
// passes. The next request can transfer in the first cycle that rsp_valid is high.
// A new request is taken even while an earlier result sits stalled in the result
// register; the sequencer then holds its own result until the register frees up.
// Reset empties the list (count to zero) and drops any pending result.
module indexed_list_table_engine import ilte_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ctl_t ctl;
  rsp_t result;
  logic accept;
  logic out_free;

  // Take a request only while the sequencer sits idle.
  assign req_stall = !ctl.idle;
  assign accept    = req_valid && !req_stall;

  // Result register is free when empty or transferring this cycle.
  assign out_free = !rsp_valid || !rsp_stall;

  ilte_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .take     (accept),
    .req      (req),
    .out_free (out_free),
    .ctl      (ctl),
    .result   (result)
  );

  // Load a finished result; hold it while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      rsp <= result;
    end
  end

  // An accepted request keeps the engine busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("engine took a request but did not go busy");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.done |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while stalled");

  // An empty-list failure reports no entries and no data.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_EMPTY) |->
      (rsp.entry_count == 5'd0 && rsp.read_value == 32'sd0))
    else $error("empty status with nonzero count or data");

  // A failed find reports index zero.
  a_notfound_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_NOTFOUND) |-> (rsp.match_index == 8'd0))
    else $error("not-found result with nonzero index");

endmodule

/* tb/sv/tb_indexed_list_table_engine.sv */
// Self-checking testbench for the indexed list table engine: directed corner cases plus random traffic.
module tb_indexed_list_table_engine;
  import ilte_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int LIMIT_CYCLES = 1_000_000;
  // Length of the forced stall on the result side during the pressure test.
  localparam int HOLD_CYCLES  = 300;
  // Quiet time after the last result; covers a full sort and then some.
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 620;
  // Request codes past the last defined one; the block answers them with status OK, zero data and zero index.
  localparam logic [3:0] OP_UNUSED_FIRST = 4'd12;
  localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shadow copy of the list contents, advanced at every accepted request.
  logic signed [31:0] list_vals [DEPTH];
  int list_len = 0;

  // Results owed by the block, oldest first.
  rsp_t replies_due [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  grow_phase = 1'b1;
  bit  hold_request = 1'b0;

  indexed_list_table_engine #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one request to the shadow list and return the result it must produce.
  function automatic rsp_t list_apply(input req_t r);
    rsp_t o;
    int p, q, i, j;
    logic signed [31:0] t;
    bit hit;
    o = '0;
    p = r.position;
    q = r.other_position;
    hit = 1'b0;
    case (r.req_type)
      OP_PUSH: begin
        if (list_len >= DEPTH) o.status = ST_FULL;
        else begin
          list_vals[list_len] = r.item_value;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) o.status = ST_EMPTY;
        else begin
          list_len--;
          o.read_value = list_vals[list_len];
        end
      end
      OP_INSERT: begin
        // Range check wins over the full check; position == length appends.
        if (p > list_len) o.status = ST_RANGE;
        else if (list_len >= DEPTH) o.status = ST_FULL;
        else begin
          for (i = list_len; i > p; i--) list_vals[i] = list_vals[i - 1];
          list_vals[p] = r.item_value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (p >= list_len) o.status = ST_RANGE;
        else begin
          for (i = p; i < list_len - 1; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
        end
      end
      OP_READ: begin
        if (p >= list_len) o.status = ST_RANGE;
        else o.read_value = list_vals[p];
      end
      OP_WRITE: begin
        if (p >= list_len) o.status = ST_RANGE;
        else list_vals[p] = r.item_value;
      end
      OP_FRONT: begin
        if (list_len == 0) o.status = ST_EMPTY;
        else o.read_value = list_vals[0];
      end
      OP_BACK: begin
        if (list_len == 0) o.status = ST_EMPTY;
        else o.read_value = list_vals[list_len - 1];
      end
      OP_FIND: begin
        o.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (!hit && list_vals[i] == r.item_value) begin
            hit = 1'b1;
            o.match_index = 8'(i);
            o.status = ST_OK;
          end
        end
      end
      OP_SWAP: begin
        if (p >= list_len || q >= list_len) o.status = ST_RANGE;
        else begin
          t = list_vals[p];
          list_vals[p] = list_vals[q];
          list_vals[q] = t;
        end
      end
      OP_SORT: begin
        // Signed ascending; equal keys are identical values, so any sort order matches.
        for (i = 0; i < list_len - 1; i++) begin
          for (j = 0; j < list_len - 1 - i; j++) begin
            if (list_vals[j + 1] < list_vals[j]) begin
              t = list_vals[j];
              list_vals[j] = list_vals[j + 1];
              list_vals[j + 1] = t;
            end
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    o.entry_count = 5'(list_len);
    return o;
  endfunction

  function automatic req_t make_req(input logic [3:0] op, input int pos, input int pos2,
                                    input logic signed [31:0] val);
    req_t r;
    r.req_type       = op;
    r.position       = 8'(pos);
    r.other_position = 8'(pos2);
    r.item_value     = val;
    return r;
  endfunction

  // Mix of extremes, a narrow band that produces duplicates, and full-range noise.
  function automatic logic signed [31:0] random_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (roll < 35) return 32'($urandom_range(8)) - 32'sd4;
    return $urandom();
  endfunction

  // Pick a request that mostly hits valid indexes of the current list.
  function automatic req_t random_request();
    req_t r;
    logic [3:0] op;
    int roll, pos, pos2;
    logic signed [31:0] val;
    roll = $urandom_range(99);
    if (roll < (grow_phase ? 30 : 8)) op = OP_PUSH;
    else if (roll < (grow_phase ? 44 : 14)) op = OP_INSERT;
    else if (roll < (grow_phase ? 50 : 32)) op = OP_POP;
    else if (roll < (grow_phase ? 55 : 46)) op = OP_REMOVE;
    else if (roll < 63) op = OP_READ;
    else if (roll < 70) op = OP_WRITE;
    else if (roll < 73) op = OP_FRONT;
    else if (roll < 76) op = OP_BACK;
    else if (roll < 86) op = OP_FIND;
    else if (roll < 94) op = OP_SWAP;
    else if (roll < 96) op = OP_SORT;
    else if (roll < 97) op = OP_CLEAR;
    else op = 4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    // Mostly in 0..length (length itself is the append slot or a range miss), sometimes wild.
    pos  = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(list_len);
    pos2 = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(list_len);
    val  = random_value();
    // Key a find on a live entry most of the time.
    if (op == OP_FIND && list_len > 0 && $urandom_range(9) < 7)
      val = list_vals[$urandom_range(list_len - 1)];
    r = make_req(op, pos, pos2, val);
    return r;
  endfunction

  // Offer one request and hold it until the transfer; the sender may idle between bursts.
  task automatic send_req(input req_t r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(8);
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    replies_due.push_back(list_apply(r));
  endtask

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at cycle %0d: expected %0d, got %0d", what, cycle_count, want, got);
  endtask

  // Result side: stall on a pattern of its own, with an occasional long hold-off on request.
  initial begin : result_stall_gen
    int seg_left, pct, hold_left;
    seg_left = 0;
    pct = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 80);
          case ($urandom_range(3))
            0: pct = 0;
            1: pct = 20;
            2: pct = 50;
            default: pct = 85;
          endcase
        end
        seg_left--;
        rsp_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  // Compare each result transfer with the oldest owed result, field by field.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("unrequested result (entry_count)", -1, longint'(rsp.entry_count));
      end else begin
        want = replies_due.pop_front();
        if (rsp.read_value !== want.read_value)
          flag_mismatch("read_value", longint'(want.read_value), longint'(rsp.read_value));
        if (rsp.match_index !== want.match_index)
          flag_mismatch("match_index", longint'(want.match_index), longint'(rsp.match_index));
        if (rsp.status !== want.status)
          flag_mismatch("status", longint'(want.status), longint'(rsp.status));
        if (rsp.entry_count !== want.entry_count)
          flag_mismatch("entry_count", longint'(want.entry_count), longint'(rsp.entry_count));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results owed", cycle_count, replies_due.size());
    $display("tb: failure");
    $finish;
  end

  // Accesses on an empty list: taking ops report empty, indexed ops report range, find misses, sort is a no-op.
  task automatic test_empty_list();
    send_req(make_req(OP_POP, 0, 0, 32'sd0));
    send_req(make_req(OP_FRONT, 0, 0, 32'sd0));
    send_req(make_req(OP_BACK, 0, 0, 32'sd0));
    send_req(make_req(OP_READ, 0, 0, 32'sd0));
    send_req(make_req(OP_REMOVE, 255, 0, 32'sd0));
    send_req(make_req(OP_FIND, 0, 0, 32'sd0));
    send_req(make_req(OP_SORT, 0, 0, 32'sd0));
  endtask

  // Insert at the front of an empty list, fill every slot, then hit the full cases.
  task automatic test_fill_to_full();
    int k;
    send_req(make_req(OP_INSERT, 0, 0, VAL_MIN));
    send_req(make_req(OP_PUSH, 0, 0, VAL_MAX));
    for (k = 2; k < DEPTH; k++)
      send_req(make_req(OP_PUSH, 0, 0, 32'(k % 5) - 32'sd2));
    send_req(make_req(OP_PUSH, 0, 0, 32'sd7));
    // Range check takes precedence over full.
    send_req(make_req(OP_INSERT, DEPTH + 1, 0, 32'sd7));
    send_req(make_req(OP_INSERT, DEPTH, 0, 32'sd7));
  endtask

  // Swap, search, sort and trim the full list, then clear it and try the leftovers.
  task automatic test_reorder_and_search();
    send_req(make_req(OP_SWAP, 0, DEPTH - 1, 32'sd0));
    send_req(make_req(OP_SWAP, 7, 7, 32'sd0));
    send_req(make_req(OP_SWAP, 3, 255, 32'sd0));
    // Duplicated key: the lowest index must win.
    send_req(make_req(OP_FIND, 0, 0, -32'sd2));
    send_req(make_req(OP_FIND, 0, 0, 32'sd12345));
    send_req(make_req(OP_SORT, 0, 0, 32'sd0));
    send_req(make_req(OP_REMOVE, 0, 0, 32'sd0));
    send_req(make_req(OP_BACK, 0, 0, 32'sd0));
    send_req(make_req(OP_CLEAR, 0, 0, 32'sd0));
    send_req(make_req(OP_WRITE, 0, 0, VAL_MAX));
    send_req(make_req(OP_UNUSED_LAST, 255, 255, -32'sd1));
  endtask

  // Hold off the result side for a long stretch while requests keep coming back to back.
  task automatic test_backpressure();
    int k;
    hold_request = 1'b1;
    burst_left = 40;
    for (k = 0; k < 30; k++) begin
      case (k % 3)
        0: send_req(make_req(OP_PUSH, 0, 0, random_value()));
        1: send_req(make_req(OP_READ, $urandom_range(list_len), 0, 32'sd0));
        default: send_req(make_req(OP_FIND, 0, 0, random_value()));
      endcase
    end
  endtask

  // Mostly well-formed traffic that swings between growing and shrinking the list.
  task automatic test_random_traffic();
    int done_items;
    req_t r;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if ($urandom_range(49) == 0) grow_phase = !grow_phase;
      r = random_request();
      send_req(r);
      // Unused codes do nothing to the list; do not count them.
      if (r.req_type < OP_UNUSED_FIRST) done_items++;
    end
  endtask

  initial begin : run
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_fill_to_full();
    test_reorder_and_search();
    test_backpressure();
    test_random_traffic();

    // Drop valid and drain everything still owed.
    @(negedge clk);
    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ilte_pkg.sv
hw/rtl/ilte_alu.sv
hw/rtl/ilte_seq.sv
hw/rtl/indexed_list_table_engine.sv
tb/sv/tb_indexed_list_table_engine.sv
